FILE: sv/xmc_pkg.sv
// Shared types, protocol codes and defaults for the XMODEM checksum receiver.
`default_nettype none

package xmc_pkg;

    localparam int PAGE_BYTES_DEF      = 256;
    localparam int FLASH_ADDR_BITS_DEF = 17;
    localparam int ADDR_BITS_MAX       = 24;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [7:0] SOH_CODE = 8'h01;
    localparam logic [7:0] EOT_CODE = 8'h04;
    localparam logic [7:0] ACK_CODE = 8'h06;
    localparam logic [7:0] NAK_CODE = 8'h15;
    localparam logic [7:0] CAN_CODE = 8'h18;

    localparam logic [8:0] HDR_SUM        = 9'h0FF;
    localparam logic [6:0] PKT_LAST_INDEX = 7'd127;
    localparam logic [3:0] ERR_COUNT_MAX  = 4'd15;
    localparam logic [3:0] ERR_LIMIT_RST  = 4'd10;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_PAGE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_NUM  = 3'd1,
        PH_COMP = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 reply_byte;
        logic [7:0]                 data_byte;
        logic [7:0]                 buffer_offset;
        logic [ADDR_BITS_MAX-1:0]   page_address;
        logic                       finished;
        logic                       last;
    } t_result;

    // Results of one input beat: zero, one or two entries, first in slot 0.
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_res_pair;

endpackage

`default_nettype wire

FILE: sv/xmc_core.sv
// Protocol state machine: packet framing, checks, page layout and replies.
`default_nettype none

module xmc_core #(
    parameter int PAGE_BYTES      = xmc_pkg::PAGE_BYTES_DEF,
    parameter int FLASH_ADDR_BITS = xmc_pkg::FLASH_ADDR_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_data,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_tmo,
    output xmc_pkg::t_res_pair      o_res
);
    import xmc_pkg::*;

    t_phase                     r_phase, n_phase;
    logic                       r_bff, n_bff;
    logic [7:0]                 r_exp, n_exp;
    logic [7:0]                 r_hdr, n_hdr;
    logic                       r_hdr_bad, n_hdr_bad;
    logic [6:0]                 r_idx, n_idx;
    logic [7:0]                 r_sum, n_sum;
    logic [3:0]                 r_err, n_err;
    logic                       r_upper, n_upper;
    logic [FLASH_ADDR_BITS-1:0] r_base, n_base;
    logic [3:0]                 r_err_limit;

    logic [7:0] w_b;
    logic       w_cancel;
    logic       w_sum_fail;
    logic       w_data_tmo;
    logic       w_hunt_fail;
    logic       w_stop;

    assign w_b         = i_tmo ? 8'h00 : i_byte;
    assign w_cancel    = !r_bff && (r_err > r_err_limit);
    assign w_sum_fail  = r_hdr_bad || i_tmo || (r_sum != w_b);
    assign w_data_tmo  = (r_phase == PH_DATA) && i_tmo;
    assign w_hunt_fail = (r_phase == PH_HUNT) && i_tmo;
    assign w_stop      = (r_phase == PH_HUNT) && !i_tmo
                         && (w_b == EOT_CODE || w_b == CAN_CODE);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_tmo) begin
                    n_phase = w_cancel ? PH_DONE : PH_HUNT;
                end else if (w_b == SOH_CODE) begin
                    n_phase = PH_NUM;
                end else if (w_stop) begin
                    n_phase = PH_DONE;
                end
            end
            PH_NUM:  n_phase = PH_COMP;
            PH_COMP: n_phase = PH_DATA;
            PH_DATA: begin
                if (i_tmo) begin
                    n_phase = w_cancel ? PH_DONE : PH_HUNT;
                end else if (r_idx == PKT_LAST_INDEX) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM:  n_phase = (w_sum_fail && w_cancel) ? PH_DONE : PH_HUNT;
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    // Datapath updates and results
    always_comb begin
        logic    v_fail;
        logic    v_good;
        logic    v_page;
        logic    v_data;
        logic    v_reply;
        logic    v_done;
        t_result v_a;
        t_result v_r;

        n_bff     = r_bff;
        n_exp     = r_exp;
        n_hdr     = r_hdr;
        n_hdr_bad = r_hdr_bad;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_err     = r_err;
        n_upper   = r_upper;
        n_base    = r_base;

        v_fail  = w_hunt_fail || w_data_tmo || ((r_phase == PH_SUM) && w_sum_fail);
        v_good  = (r_phase == PH_SUM) && !w_sum_fail;
        v_data  = (r_phase == PH_DATA);
        v_page  = w_stop;
        v_done  = (n_phase == PH_DONE) && (r_phase != PH_DONE);
        v_reply = v_fail || v_good || w_stop;

        v_a = '0;
        v_r = '0;
        v_r.kind = KIND_REPLY;

        unique case (r_phase)
            PH_NUM: n_hdr = w_b;
            PH_COMP: begin
                n_hdr_bad = (({1'b0, r_hdr} + {1'b0, w_b}) != HDR_SUM) || (r_hdr != r_exp);
                n_idx     = '0;
                n_sum     = '0;
            end
            PH_DATA: begin
                n_sum = r_sum + w_b;
                if (!i_tmo) begin
                    n_idx = (r_idx == PKT_LAST_INDEX) ? 7'd0 : r_idx + 7'd1;
                end
            end
            default: ;
        endcase

        if (v_fail) begin
            if (r_bff) begin
                v_r.reply_byte = NAK_CODE;
            end else if (w_cancel) begin
                v_r.reply_byte = CAN_CODE;
            end else begin
                if (r_err < ERR_COUNT_MAX) begin
                    n_err = r_err + 4'd1;
                end
                v_r.reply_byte = NAK_CODE;
            end
        end else if (w_stop) begin
            n_bff          = 1'b0;
            v_r.reply_byte = ACK_CODE;
        end else if (v_good) begin
            n_bff = 1'b0;
            if (PAGE_BYTES != 128 && r_exp[0]) begin
                n_upper = 1'b1;
            end else begin
                v_page  = 1'b1;
                n_base  = r_base + FLASH_ADDR_BITS'(PAGE_BYTES);
                n_upper = 1'b0;
            end
            n_err          = '0;
            n_exp          = r_exp + 8'd1;
            v_r.reply_byte = ACK_CODE;
        end

        if (v_data) begin
            v_a.kind          = KIND_DATA;
            v_a.data_byte     = w_b;
            v_a.buffer_offset = {r_upper, r_idx};
        end else begin
            v_a.kind         = KIND_PAGE;
            v_a.page_address = ADDR_BITS_MAX'(r_base);
        end
        v_a.finished = v_done;
        v_r.finished = v_done;
        v_r.last     = 1'b1;

        o_res = '0;
        if (v_data || v_page) begin
            v_a.last  = !v_reply;
            o_res.slot0 = v_a;
            o_res.slot1 = v_r;
            o_res.count = v_reply ? 2'd2 : 2'd1;
        end else if (v_reply) begin
            o_res.slot0 = v_r;
            o_res.count = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_bff       <= 1'b1;
            r_exp       <= 8'd1;
            r_hdr       <= '0;
            r_hdr_bad   <= 1'b0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_err       <= '0;
            r_upper     <= 1'b0;
            r_base      <= '0;
            r_err_limit <= ERR_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                r_err_limit <= i_cfg_data;
            end
            if (i_take) begin
                r_phase   <= n_phase;
                r_bff     <= n_bff;
                r_exp     <= n_exp;
                r_hdr     <= n_hdr;
                r_hdr_bad <= n_hdr_bad;
                r_idx     <= n_idx;
                r_sum     <= n_sum;
                r_err     <= n_err;
                r_upper   <= n_upper;
                r_base    <= n_base;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/xmc_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
`default_nettype none

module xmc_out_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire xmc_pkg::t_res_pair  i_res,
    input  wire logic                i_push,
    input  wire logic                i_pop,
    output xmc_pkg::t_result         o_head,
    output logic                     o_valid,
    output logic                     o_room2
);
    import xmc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_result              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr, n_wr;
    logic [PTR_BITS-1:0]  r_rd, n_rd;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [1:0]           w_push_n;
    logic                 w_pop;

    assign o_valid  = (r_cnt != '0);
    assign o_room2  = (r_cnt <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign o_head   = r_mem[r_rd];
    assign w_pop    = i_pop && o_valid;
    assign w_push_n = i_push ? i_res.count : 2'd0;

    always_comb begin
        n_wr  = r_wr + PTR_BITS'(w_push_n);
        n_rd  = r_rd + PTR_BITS'(w_pop);
        n_cnt = r_cnt + CNT_BITS'(w_push_n) - CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res.slot0;
        end
        if (w_push_n == 2'd2) begin
            r_mem[r_wr + PTR_BITS'(1)] <= i_res.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: sv/xmodem_checksum_receiver.sv
// Top level of the XMODEM checksum receiver: input register, core, result queue.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_rx_byte, i_timed_out
//  out     | from block| o_out_valid / i_out_stall | o_kind .. o_page_address, o_finished,
//          |           |                           | o_last
//  cfg     | to block  | i_cfg_we                  | i_cfg_data (error_limit)
//
// A beat lands in the input register, and the core processes it once the queue has room
// for two results, pushing zero to two results into a four-entry queue; one beat per cycle
// is taken while the queue has room for two results. Results leave one per cycle while the
// output is not stalled, so the output port sets the pace of beats that cause two results.
// Synchronous active-low reset returns to hunting for SOH with error_limit 10.
// Stall on the output fills the queue and then stalls the input.
`default_nettype none

module xmodem_checksum_receiver #(
    parameter int PAGE_BYTES      = xmc_pkg::PAGE_BYTES_DEF,
    parameter int FLASH_ADDR_BITS = xmc_pkg::FLASH_ADDR_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [3:0]                 i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [7:0]                 i_rx_byte,
    input  wire logic                       i_timed_out,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_reply_byte,
    output logic [7:0]                      o_data_byte,
    output logic [7:0]                      o_buffer_offset,
    output logic [FLASH_ADDR_BITS-1:0]      o_page_address,
    output logic                            o_finished,
    output logic                            o_last
);
    import xmc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_tmo;
    logic       w_take;
    logic       w_room2;
    t_res_pair  w_res;
    t_result    w_head;

    assign w_take     = r_in_valid && w_room2;
    assign o_in_stall = r_in_valid && !w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
            r_in_tmo  <= i_timed_out;
        end
    end

    xmc_core #(
        .PAGE_BYTES      (PAGE_BYTES),
        .FLASH_ADDR_BITS (FLASH_ADDR_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (w_take),
        .i_byte     (r_in_byte),
        .i_tmo      (r_in_tmo),
        .o_res      (w_res)
    );

    xmc_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .i_push  (w_take),
        .i_pop   (!i_out_stall),
        .o_head  (w_head),
        .o_valid (o_out_valid),
        .o_room2 (w_room2)
    );

    assign o_kind          = w_head.kind;
    assign o_reply_byte    = w_head.reply_byte;
    assign o_data_byte     = w_head.data_byte;
    assign o_buffer_offset = w_head.buffer_offset;
    assign o_page_address  = w_head.page_address[FLASH_ADDR_BITS-1:0];
    assign o_finished      = w_head.finished;
    assign o_last          = w_head.last;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the XMODEM checksum receiver: packet stimulus, predictor, checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xmc_pkg::*;

    localparam int PAGE_BYTES   = PAGE_BYTES_DEF;
    localparam int ADDR_BITS    = FLASH_ADDR_BITS_DEF;
    localparam int PHASE_ITEMS  = 170;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_CYCS  = 16;
    localparam int STUCK_LIMIT  = 4000;

    localparam logic [ADDR_BITS-1:0] PAGE_STEP = ADDR_BITS'(PAGE_BYTES);

    typedef enum int {OC_PASS, OC_STOP, OC_FAIL} t_outcome;

    typedef enum int {
        PKT_GOOD,
        PKT_BAD_NUM,
        PKT_BAD_COMP,
        PKT_BAD_SUM,
        PKT_TMO_HDR,
        PKT_TMO_DATA,
        PKT_TMO_SUM
    } t_pkt_mode;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           reply;
        logic [7:0]           data;
        logic [7:0]           offset;
        logic [ADDR_BITS-1:0] addr;
        logic                 fin;
        logic                 last;
    } t_rx_result;

    class xfer_tracker;
        logic [3:0]           err_limit;
        t_phase               phase;
        bit                   no_good_yet;
        logic [7:0]           exp_num;
        logic [7:0]           hdr_num;
        bit                   hdr_bad;
        logic [6:0]           idx;
        logic [7:0]           sum;
        logic [3:0]           err_cnt;
        bit                   upper;
        logic [ADDR_BITS-1:0] page_base;
        t_rx_result           pending_results[$];
        t_rx_result           step_res[$];
        int unsigned          errors;

        function new();
            err_limit   = ERR_LIMIT_RST;
            phase       = PH_HUNT;
            no_good_yet = 1'b1;
            exp_num     = 8'd1;
            hdr_num     = 8'd0;
            hdr_bad     = 1'b0;
            idx         = '0;
            sum         = 8'd0;
            err_cnt     = 4'd0;
            upper       = 1'b0;
            page_base   = '0;
            errors      = 0;
        endfunction

        // A failure here answers NAK rather than ending the transfer.
        function bit may_fail();
            return no_good_yet || (err_cnt <= err_limit);
        endfunction

        function void add(t_kind k, logic [7:0] reply, logic [7:0] data, logic [7:0] offs,
                          logic [ADDR_BITS-1:0] addr);
            t_rx_result r;
            r.kind   = k;
            r.reply  = reply;
            r.data   = data;
            r.offset = offs;
            r.addr   = addr;
            r.fin    = 1'b0;
            r.last   = 1'b0;
            step_res.push_back(r);
        endfunction

        function void close_packet(t_outcome oc);
            if (oc == OC_FAIL) begin
                if (no_good_yet) begin
                    add(KIND_REPLY, NAK_CODE, 8'h00, 8'h00, '0);
                end else if (err_cnt > err_limit) begin
                    add(KIND_REPLY, CAN_CODE, 8'h00, 8'h00, '0);
                    phase = PH_DONE;
                end else begin
                    if (err_cnt != ERR_COUNT_MAX) err_cnt++;
                    add(KIND_REPLY, NAK_CODE, 8'h00, 8'h00, '0);
                end
                return;
            end
            no_good_yet = 1'b0;
            if (oc == OC_STOP) begin
                add(KIND_PAGE, 8'h00, 8'h00, 8'h00, page_base);
                add(KIND_REPLY, ACK_CODE, 8'h00, 8'h00, '0);
                phase = PH_DONE;
                return;
            end
            // Odd packet fills lower half; even one (any, if PAGE_BYTES is 128) ends the page.
            if (PAGE_BYTES != 128 && exp_num[0]) begin
                upper = 1'b1;
            end else begin
                add(KIND_PAGE, 8'h00, 8'h00, 8'h00, page_base);
                page_base = page_base + PAGE_STEP;
                upper     = 1'b0;
            end
            err_cnt = 4'd0;
            exp_num = exp_num + 8'd1;
            add(KIND_REPLY, ACK_CODE, 8'h00, 8'h00, '0);
        endfunction

        function void note_beat(logic [7:0] rx, logic tmo);
            logic [7:0] b;
            b = tmo ? 8'h00 : rx;
            step_res.delete();
            case (phase)
                PH_HUNT: begin
                    if (tmo) close_packet(OC_FAIL);
                    else if (b == SOH_CODE) phase = PH_NUM;
                    else if (b == EOT_CODE || b == CAN_CODE) close_packet(OC_STOP);
                end
                PH_NUM: begin
                    hdr_num = b;
                    phase   = PH_COMP;
                end
                PH_COMP: begin
                    hdr_bad = (({1'b0, hdr_num} + {1'b0, b}) != HDR_SUM) || (hdr_num != exp_num);
                    idx     = '0;
                    sum     = 8'd0;
                    phase   = PH_DATA;
                end
                PH_DATA: begin
                    add(KIND_DATA, 8'h00, b, {upper, idx}, '0);
                    sum = sum + b;
                    if (tmo) begin
                        phase = PH_HUNT;
                        close_packet(OC_FAIL);
                    end else if (idx == PKT_LAST_INDEX) begin
                        idx   = '0;
                        phase = PH_SUM;
                    end else begin
                        idx++;
                    end
                end
                PH_SUM: begin
                    phase = PH_HUNT;
                    close_packet((hdr_bad || tmo || sum != b) ? OC_FAIL : OC_PASS);
                end
                default: ;
            endcase
            foreach (step_res[k]) begin
                step_res[k].fin  = (phase == PH_DONE);
                step_res[k].last = (k == step_res.size() - 1);
                pending_results.push_back(step_res[k]);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_rx_result got);
            t_rx_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d", got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(got.kind));
            cmp_field("reply_byte", 32'(want.reply), 32'(got.reply));
            cmp_field("data_byte", 32'(want.data), 32'(got.data));
            cmp_field("buffer_offset", 32'(want.offset), 32'(got.offset));
            cmp_field("page_address", 32'(want.addr), 32'(got.addr));
            cmp_field("finished", 32'(want.fin), 32'(got.fin));
            cmp_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [3:0]           cfg_data    = 4'd0;
    logic                 in_valid    = 1'b0;
    logic [7:0]           rx_byte     = 8'd0;
    logic                 timed_out   = 1'b0;
    logic                 out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_kind;
    logic [7:0]           o_reply_byte;
    logic [7:0]           o_data_byte;
    logic [7:0]           o_buffer_offset;
    logic [ADDR_BITS-1:0] o_page_address;
    logic                 o_finished;
    logic                 o_last;

    bit                   in_idle_en  = 1'b1;
    bit                   out_idle_en = 1'b1;
    bit                   hold_req    = 1'b0;
    int unsigned          n_sent      = 0;
    xfer_tracker          tracker     = new();

    xmodem_checksum_receiver #(
        .PAGE_BYTES      (PAGE_BYTES),
        .FLASH_ADDR_BITS (ADDR_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (rx_byte),
        .i_timed_out     (timed_out),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (o_kind),
        .o_reply_byte    (o_reply_byte),
        .o_data_byte     (o_data_byte),
        .o_buffer_offset (o_buffer_offset),
        .o_page_address  (o_page_address),
        .o_finished      (o_finished),
        .o_last          (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each accepted result, then decide the next stall.
    initial begin : result_side
        int unsigned stall_left;
        t_rx_result  seen;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !out_stall) begin
                seen.kind   = t_kind'(o_kind);
                seen.reply  = o_reply_byte;
                seen.data   = o_data_byte;
                seen.offset = o_buffer_offset;
                seen.addr   = o_page_address;
                seen.fin    = o_finished;
                seen.last   = o_last;
                tracker.check_result(seen);
            end
            if (hold_req) begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end else if (stall_left == 0 && out_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) stuck = 0;
            else stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic tmo);
        int unsigned gap;
        if (in_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        timed_out <= tmo;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_beat(b, tmo);
        n_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the core go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCS) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        tracker.err_limit = v;
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return SOH_CODE;
            3:       return EOT_CODE;
            4:       return CAN_CODE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] d;
        do d = 8'($urandom); while (d == SOH_CODE || d == EOT_CODE || d == CAN_CODE);
        return d;
    endfunction

    task automatic send_packet(input t_pkt_mode mode);
        logic [7:0] num;
        logic [7:0] comp;
        logic [7:0] sum;
        logic [7:0] d;
        int         tmo_at;
        num  = tracker.exp_num;
        comp = ~num;
        if (mode == PKT_BAD_NUM) begin
            num  = num + 8'($urandom_range(1, 255));
            comp = ~num;
        end else if (mode == PKT_BAD_COMP) begin
            comp = comp ^ 8'($urandom_range(1, 255));
        end
        send_beat(SOH_CODE, 1'b0);
        if (mode == PKT_TMO_HDR && $urandom_range(0, 1) == 0) begin
            send_beat(8'($urandom), 1'b1);
            send_beat(comp, 1'b0);
        end else if (mode == PKT_TMO_HDR) begin
            send_beat(num, 1'b0);
            send_beat(8'($urandom), 1'b1);
        end else begin
            send_beat(num, 1'b0);
            send_beat(comp, 1'b0);
        end
        tmo_at = (mode == PKT_TMO_DATA) ? $urandom_range(0, 127) : 128;
        sum    = 8'h00;
        for (int i = 0; i < 128; i++) begin
            d = pick_data();
            if (i == tmo_at) begin
                send_beat(d, 1'b1);
                return;
            end
            send_beat(d, 1'b0);
            sum = sum + d;
        end
        if (mode == PKT_TMO_SUM) send_beat(8'($urandom), 1'b1);
        else if (mode == PKT_BAD_SUM) send_beat(sum ^ 8'($urandom_range(1, 255)), 1'b0);
        else send_beat(sum, 1'b0);
    endtask

    initial begin : stimulus
        logic [3:0]  limits[4];
        int unsigned start;
        int unsigned r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored hunt bytes, unlimited NAKs before the first good frame,
        // header timeouts reading as zero, data timeout, header mismatches.
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(SOH_CODE, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hA5, 1'b1);
        send_beat(SOH_CODE, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'hFE, 1'b0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(SOH_CODE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);

        limits[0] = 4'd15;
        limits[1] = 4'd0;
        limits[2] = 4'($urandom_range(1, 14));
        limits[3] = 4'($urandom_range(0, 15));
        for (int p = 0; p < 4; p++) begin
            settle();
            write_limit(limits[p]);
            in_idle_en  = (p != 3) && ($urandom_range(0, 3) != 0);
            out_idle_en = (p != 3) && ($urandom_range(0, 3) != 0);
            if (p == 0) begin
                // Drive the error count into saturation while nothing can cancel.
                send_packet(PKT_GOOD);
                repeat (17) send_beat(8'($urandom), 1'b1);
            end
            if (p == 1) hold_req = 1'b1;
            start = n_sent;
            while (n_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    if (tracker.may_fail() && $urandom_range(0, 2) == 0)
                        send_beat(8'($urandom), 1'b1);
                    else
                        send_beat(pick_noise(), 1'b0);
                end else if (r < 45 && tracker.may_fail()) begin
                    send_packet(t_pkt_mode'($urandom_range(1, 6)));
                end else begin
                    send_packet(PKT_GOOD);
                end
            end
        end

        // Close the transfer once, then show that later beats are ignored.
        settle();
        write_limit(4'($urandom_range(0, 14)));
        r = $urandom_range(0, 2);
        if (r == 0 || tracker.no_good_yet) begin
            send_beat(EOT_CODE, 1'b0);
        end else if (r == 1) begin
            send_beat(CAN_CODE, 1'b0);
        end else begin
            while (tracker.phase != PH_DONE) send_beat(8'($urandom), 1'b1);
        end
        send_beat(SOH_CODE, 1'b0);
        send_beat(EOT_CODE, 1'b0);
        repeat (4) send_beat(8'($urandom), 1'($urandom));
        settle();

        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
